### design/dsr_pkg.sv
// shared types, action codes and helpers for the dual stack rotate engine
package dsr_pkg;

    localparam int DEPTH       = 512;
    localparam int VALUE_WIDTH = 32;
    localparam int PTR_W       = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int COUNT_W     = 10;
    localparam int ACTION_W    = 4;
    localparam int MODE_W      = 3;

    typedef logic [PTR_W-1:0]       ptr_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [CNT_W:0]         sum_t;
    typedef logic [VALUE_WIDTH-1:0] val_t;

    localparam logic [ACTION_W-1:0] ACT_LOAD_A = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_SA     = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_SB     = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_SS     = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_PA     = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_PB     = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_RA     = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_RB     = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_RR     = 4'd8;
    localparam logic [ACTION_W-1:0] ACT_RRA    = 4'd9;
    localparam logic [ACTION_W-1:0] ACT_RRB    = 4'd10;
    localparam logic [ACTION_W-1:0] ACT_RRR    = 4'd11;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 4'd12;

    // what one action does to one stack
    localparam logic [MODE_W-1:0] MODE_NONE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SWAP     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ROT      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RROT     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PUSH_SRC = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PUSH_DST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_LOAD     = 3'd6;

    typedef struct packed {
        logic [MODE_W-1:0] mode_a;
        logic [MODE_W-1:0] mode_b;
        logic              is_clear;
        val_t              value;
    } op_t;

    function automatic val_t to_val(input logic signed [DATA_W-1:0] x);
        logic [63:0] e;
        e = {{32{x[DATA_W-1]}}, x};
        return e[VALUE_WIDTH-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] to_out(input val_t v);
        logic [63:0] z;
        z = 64'(v);
        return signed'(z[DATA_W-1:0]);
    endfunction

endpackage

### design/dsr_if.sv
// request and response channel interfaces
interface dsr_req_if;
    logic                                    valid;
    logic                                    ready;
    logic [dsr_pkg::ACTION_W-1:0]            action;
    logic signed [dsr_pkg::DATA_W-1:0]       load_value;

    modport source (output valid, output action, output load_value, input ready);
    modport sink (input valid, input action, input load_value, output ready);
endinterface

interface dsr_rsp_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [dsr_pkg::DATA_W-1:0]       top_a;
    logic signed [dsr_pkg::DATA_W-1:0]       top_b;
    logic [dsr_pkg::COUNT_W-1:0]             count_a;
    logic [dsr_pkg::COUNT_W-1:0]             count_b;
    logic                                    applied;

    modport source (output valid, output top_a, output top_b, output count_a,
                    output count_b, output applied, input ready);
    modport sink (input valid, input top_a, input top_b, input count_a,
                  input count_b, input applied, output ready);
endinterface

### design/dsr_front.sv
// front end: accepts actions, decodes them per stack and queues them
module dsr_front (
    input  logic          clk,
    input  logic          rst_n,
    dsr_req_if.sink       req,
    output logic          q_valid,
    output dsr_pkg::op_t  q_op,
    input  logic          q_pop
);

    dsr_pkg::op_t q_mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   cnt_reg;
    logic [1:0]   cnt_next;
    logic         push;
    logic         pop;
    dsr_pkg::op_t dec_op;

    always_comb
    begin
        dec_op.mode_a   = dsr_pkg::MODE_NONE;
        dec_op.mode_b   = dsr_pkg::MODE_NONE;
        dec_op.is_clear = 1'b0;
        dec_op.value    = dsr_pkg::to_val(req.load_value);
        case (req.action)
            dsr_pkg::ACT_LOAD_A: dec_op.mode_a = dsr_pkg::MODE_LOAD;
            dsr_pkg::ACT_SA:     dec_op.mode_a = dsr_pkg::MODE_SWAP;
            dsr_pkg::ACT_SB:     dec_op.mode_b = dsr_pkg::MODE_SWAP;
            dsr_pkg::ACT_SS:
            begin
                dec_op.mode_a = dsr_pkg::MODE_SWAP;
                dec_op.mode_b = dsr_pkg::MODE_SWAP;
            end
            dsr_pkg::ACT_PA:
            begin
                dec_op.mode_a = dsr_pkg::MODE_PUSH_DST;
                dec_op.mode_b = dsr_pkg::MODE_PUSH_SRC;
            end
            dsr_pkg::ACT_PB:
            begin
                dec_op.mode_a = dsr_pkg::MODE_PUSH_SRC;
                dec_op.mode_b = dsr_pkg::MODE_PUSH_DST;
            end
            dsr_pkg::ACT_RA:     dec_op.mode_a = dsr_pkg::MODE_ROT;
            dsr_pkg::ACT_RB:     dec_op.mode_b = dsr_pkg::MODE_ROT;
            dsr_pkg::ACT_RR:
            begin
                dec_op.mode_a = dsr_pkg::MODE_ROT;
                dec_op.mode_b = dsr_pkg::MODE_ROT;
            end
            dsr_pkg::ACT_RRA:    dec_op.mode_a = dsr_pkg::MODE_RROT;
            dsr_pkg::ACT_RRB:    dec_op.mode_b = dsr_pkg::MODE_RROT;
            dsr_pkg::ACT_RRR:
            begin
                dec_op.mode_a = dsr_pkg::MODE_RROT;
                dec_op.mode_b = dsr_pkg::MODE_RROT;
            end
            dsr_pkg::ACT_CLEAR:  dec_op.is_clear = 1'b1;
            default:             dec_op.is_clear = 1'b0;
        endcase
    end

    assign req.ready = (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign pop       = q_pop && q_valid;
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_op      = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= dec_op;
    end

endmodule

### design/dsr_back.sv
// back end: sequencer over the two stack memories and the response register
module dsr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  dsr_pkg::op_t  q_op,
    output logic          q_pop,
    dsr_rsp_if.source     rsp
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD1  = 3'd1;
    localparam logic [2:0] ST_RD2  = 3'd2;
    localparam logic [2:0] ST_WR1  = 3'd3;
    localparam logic [2:0] ST_WR2  = 3'd4;
    localparam logic [2:0] ST_TOP  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    typedef struct packed {
        logic          re;
        logic          we;
        dsr_pkg::ptr_t addr;
        dsr_pkg::val_t wdata;
    } mem_ctl_t;

    function automatic dsr_pkg::ptr_t wrap_add(input dsr_pkg::ptr_t base,
                                               input dsr_pkg::cnt_t off);
        dsr_pkg::sum_t s;
        s = dsr_pkg::sum_t'(base) + dsr_pkg::sum_t'(off);
        if (s >= dsr_pkg::sum_t'(dsr_pkg::DEPTH))
            s = s - dsr_pkg::sum_t'(dsr_pkg::DEPTH);
        return dsr_pkg::ptr_t'(s);
    endfunction

    function automatic dsr_pkg::ptr_t wrap_dec(input dsr_pkg::ptr_t base);
        return (base == dsr_pkg::ptr_t'(0)) ? dsr_pkg::ptr_t'(dsr_pkg::DEPTH - 1)
                                            : base - dsr_pkg::ptr_t'(1);
    endfunction

    function automatic logic stack_en(input logic [dsr_pkg::MODE_W-1:0] mode,
                                      input dsr_pkg::cnt_t own,
                                      input dsr_pkg::cnt_t other);
        dsr_pkg::sum_t s;
        logic          en;
        s = dsr_pkg::sum_t'(own) + dsr_pkg::sum_t'(other);
        case (mode)
            dsr_pkg::MODE_SWAP,
            dsr_pkg::MODE_ROT,
            dsr_pkg::MODE_RROT:     en = (own >= dsr_pkg::cnt_t'(2));
            dsr_pkg::MODE_PUSH_SRC: en = (own != dsr_pkg::cnt_t'(0));
            dsr_pkg::MODE_PUSH_DST: en = (other != dsr_pkg::cnt_t'(0));
            dsr_pkg::MODE_LOAD:     en = (s < dsr_pkg::sum_t'(dsr_pkg::DEPTH));
            default:                en = 1'b0;
        endcase
        return en;
    endfunction

    function automatic mem_ctl_t stack_port(input logic [2:0] st,
                                            input logic [dsr_pkg::MODE_W-1:0] mode,
                                            input logic en,
                                            input dsr_pkg::ptr_t head,
                                            input dsr_pkg::cnt_t fill,
                                            input dsr_pkg::val_t rdata,
                                            input dsr_pkg::val_t hold,
                                            input dsr_pkg::val_t other_hold,
                                            input dsr_pkg::val_t value);
        mem_ctl_t c;
        c.re    = 1'b0;
        c.we    = 1'b0;
        c.addr  = head;
        c.wdata = hold;
        if (st == ST_TOP)
            c.re = 1'b1;
        else if (en)
        begin
            case (mode)
                dsr_pkg::MODE_SWAP:
                begin
                    case (st)
                        ST_RD1: c.re = 1'b1;
                        ST_RD2:
                        begin
                            c.re   = 1'b1;
                            c.addr = wrap_add(head, dsr_pkg::cnt_t'(1));
                        end
                        // second entry lands on the top slot, saved top goes below
                        ST_WR1:
                        begin
                            c.we    = 1'b1;
                            c.wdata = rdata;
                        end
                        ST_WR2:
                        begin
                            c.we   = 1'b1;
                            c.addr = wrap_add(head, dsr_pkg::cnt_t'(1));
                        end
                        default: c.re = 1'b0;
                    endcase
                end
                dsr_pkg::MODE_ROT:
                begin
                    if (st == ST_RD1)
                        c.re = 1'b1;
                    else if (st == ST_WR1)
                    begin
                        c.we   = 1'b1;
                        c.addr = wrap_add(head, fill);
                    end
                end
                dsr_pkg::MODE_RROT:
                begin
                    if (st == ST_RD1)
                    begin
                        c.re   = 1'b1;
                        c.addr = wrap_add(head, fill - dsr_pkg::cnt_t'(1));
                    end
                    else if (st == ST_WR1)
                    begin
                        c.we   = 1'b1;
                        c.addr = wrap_dec(head);
                    end
                end
                dsr_pkg::MODE_PUSH_SRC:
                begin
                    if (st == ST_RD1)
                        c.re = 1'b1;
                end
                dsr_pkg::MODE_PUSH_DST:
                begin
                    if (st == ST_WR1)
                    begin
                        c.we    = 1'b1;
                        c.addr  = wrap_dec(head);
                        c.wdata = other_hold;
                    end
                end
                dsr_pkg::MODE_LOAD:
                begin
                    if (st == ST_WR1)
                    begin
                        c.we    = 1'b1;
                        c.addr  = wrap_add(head, fill);
                        c.wdata = value;
                    end
                end
                default: c.re = 1'b0;
            endcase
        end
        return c;
    endfunction

    function automatic dsr_pkg::ptr_t next_head(input logic [dsr_pkg::MODE_W-1:0] mode,
                                                input logic en,
                                                input dsr_pkg::ptr_t head);
        dsr_pkg::ptr_t h;
        h = head;
        if (en)
        begin
            case (mode)
                dsr_pkg::MODE_ROT,
                dsr_pkg::MODE_PUSH_SRC: h = wrap_add(head, dsr_pkg::cnt_t'(1));
                dsr_pkg::MODE_RROT,
                dsr_pkg::MODE_PUSH_DST: h = wrap_dec(head);
                default:                h = head;
            endcase
        end
        return h;
    endfunction

    function automatic dsr_pkg::cnt_t next_fill(input logic [dsr_pkg::MODE_W-1:0] mode,
                                                input logic en,
                                                input dsr_pkg::cnt_t fill);
        dsr_pkg::cnt_t f;
        f = fill;
        if (en)
        begin
            case (mode)
                dsr_pkg::MODE_PUSH_SRC: f = fill - dsr_pkg::cnt_t'(1);
                dsr_pkg::MODE_PUSH_DST,
                dsr_pkg::MODE_LOAD:     f = fill + dsr_pkg::cnt_t'(1);
                default:                f = fill;
            endcase
        end
        return f;
    endfunction

    function automatic logic [dsr_pkg::COUNT_W-1:0] out_count(input dsr_pkg::cnt_t c);
        logic [63:0] z;
        z = 64'(c);
        return z[dsr_pkg::COUNT_W-1:0];
    endfunction

    dsr_pkg::val_t store_a [dsr_pkg::DEPTH];
    dsr_pkg::val_t store_b [dsr_pkg::DEPTH];

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    dsr_pkg::op_t                op_reg;
    logic                        en_a_reg;
    logic                        en_b_reg;
    logic                        applied_reg;
    dsr_pkg::ptr_t               head_a_reg;
    dsr_pkg::ptr_t               head_b_reg;
    dsr_pkg::cnt_t               fill_a_reg;
    dsr_pkg::cnt_t               fill_b_reg;
    dsr_pkg::val_t               hold_a_reg;
    dsr_pkg::val_t               hold_b_reg;
    dsr_pkg::val_t               rdata_a_reg;
    dsr_pkg::val_t               rdata_b_reg;
    logic                        out_valid_reg;
    logic signed [dsr_pkg::DATA_W-1:0] out_top_a_reg;
    logic signed [dsr_pkg::DATA_W-1:0] out_top_b_reg;
    logic [dsr_pkg::COUNT_W-1:0] out_count_a_reg;
    logic [dsr_pkg::COUNT_W-1:0] out_count_b_reg;
    logic                        out_applied_reg;

    logic                        start;
    logic                        commit;
    logic                        out_load;
    logic                        start_en_a;
    logic                        start_en_b;
    mem_ctl_t                    ctl_a;
    mem_ctl_t                    ctl_b;

    assign start    = (state_reg == ST_IDLE) && q_valid;
    assign q_pop    = start;
    assign commit   = (state_reg == ST_WR2);
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || rsp.ready);

    assign start_en_a = stack_en(q_op.mode_a, fill_a_reg, fill_b_reg);
    assign start_en_b = stack_en(q_op.mode_b, fill_b_reg, fill_a_reg);

    always_comb
    begin
        ctl_a = stack_port(state_reg, op_reg.mode_a, en_a_reg, head_a_reg, fill_a_reg,
                           rdata_a_reg, hold_a_reg, hold_b_reg, op_reg.value);
        ctl_b = stack_port(state_reg, op_reg.mode_b, en_b_reg, head_b_reg, fill_b_reg,
                           rdata_b_reg, hold_b_reg, hold_a_reg, op_reg.value);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (q_valid) state_next = ST_RD1;
            ST_RD1:  state_next = ST_RD2;
            ST_RD2:  state_next = ST_WR1;
            ST_WR1:  state_next = ST_WR2;
            ST_WR2:  state_next = ST_TOP;
            ST_TOP:  state_next = ST_OUT;
            ST_OUT:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            en_a_reg      <= 1'b0;
            en_b_reg      <= 1'b0;
            head_a_reg    <= '0;
            head_b_reg    <= '0;
            fill_a_reg    <= '0;
            fill_b_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (start)
            begin
                en_a_reg <= start_en_a;
                en_b_reg <= start_en_b;
            end
            if (commit)
            begin
                if (op_reg.is_clear)
                begin
                    head_a_reg <= '0;
                    head_b_reg <= '0;
                    fill_a_reg <= '0;
                    fill_b_reg <= '0;
                end
                else
                begin
                    head_a_reg <= next_head(op_reg.mode_a, en_a_reg, head_a_reg);
                    head_b_reg <= next_head(op_reg.mode_b, en_b_reg, head_b_reg);
                    fill_a_reg <= next_fill(op_reg.mode_a, en_a_reg, fill_a_reg);
                    fill_b_reg <= next_fill(op_reg.mode_b, en_b_reg, fill_b_reg);
                end
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg      <= q_op;
            applied_reg <= q_op.is_clear ? ((fill_a_reg != dsr_pkg::cnt_t'(0)) ||
                                            (fill_b_reg != dsr_pkg::cnt_t'(0)))
                                         : (start_en_a || start_en_b);
        end
        // first read returns here, kept for the write phase
        if (state_reg == ST_RD2)
        begin
            hold_a_reg <= rdata_a_reg;
            hold_b_reg <= rdata_b_reg;
        end
        if (out_load)
        begin
            out_top_a_reg   <= (fill_a_reg != dsr_pkg::cnt_t'(0)) ?
                               dsr_pkg::to_out(rdata_a_reg) : '0;
            out_top_b_reg   <= (fill_b_reg != dsr_pkg::cnt_t'(0)) ?
                               dsr_pkg::to_out(rdata_b_reg) : '0;
            out_count_a_reg <= out_count(fill_a_reg);
            out_count_b_reg <= out_count(fill_b_reg);
            out_applied_reg <= applied_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_a.we)
            store_a[ctl_a.addr] <= ctl_a.wdata;
        if (ctl_a.re)
            rdata_a_reg <= store_a[ctl_a.addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl_b.we)
            store_b[ctl_b.addr] <= ctl_b.wdata;
        if (ctl_b.re)
            rdata_b_reg <= store_b[ctl_b.addr];
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.top_a   = out_top_a_reg;
    assign rsp.top_b   = out_top_b_reg;
    assign rsp.count_a = out_count_a_reg;
    assign rsp.count_b = out_count_b_reg;
    assign rsp.applied = out_applied_reg;

endmodule

### design/dual_stack_rotate_engine.sv
// top level of the dual stack rotate engine
//
//   channel  dir  transaction                 fields
//   req      in   one action                  action, load_value
//   rsp      out  one result per action       top_a, top_b, count_a, count_b, applied
//
// each action steps the back end through two read slots, two write slots,
// a top read and the response load, set by the single port on each stack memory
// a two-entry queue keeps taking actions while the back end works or rsp stalls
// a stalled response holds the back end in its last step until rsp takes it
// rst_n clears pointers, counts and queue at once; stack memories need no clearing
module dual_stack_rotate_engine (
    input  logic      clk,
    input  logic      rst_n,
    dsr_req_if.sink   req,
    dsr_rsp_if.source rsp
);

    logic         q_valid;
    dsr_pkg::op_t q_op;
    logic         q_pop;

    dsr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_op    (q_op),
        .q_pop   (q_pop)
    );

    dsr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_op    (q_op),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

    // an empty stack always reports a zero top
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.count_a == '0)) |-> (rsp.top_a == '0))
        else $error("top_a nonzero with stack a empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.count_b == '0)) |-> (rsp.top_b == '0))
        else $error("top_b nonzero with stack b empty");

    // a full queue always offers a transaction to the back end
    assert property (@(posedge clk) disable iff (!rst_n)
        (!req.ready) |-> q_valid)
        else $error("request stalled with queue idle");

endmodule
